FILE: src/lmcr_pkg.sv
// lmcr_pkg: shared types, codes and sizes for the led matrix column refresh block
// no dependencies; imported by every module of the block
`default_nettype none

package lmcr_pkg;

	localparam int MATRIX_COLUMNS = 8;
	localparam int MATRIX_ROWS    = 8;
	localparam int STORE_PIXELS   = MATRIX_COLUMNS * MATRIX_ROWS;
	localparam int ADDR_W         = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;
	localparam int ROW_W          = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
	localparam int DOT_WORDS      = 24;
	localparam logic [7:0] DOT_ALL_ONES = 8'h3F;
	localparam logic [7:0] ENABLE_COL0  = 8'h80;

	typedef enum logic [1:0] {
		REQ_SET     = 2'd0,
		REQ_REFRESH = 2'd1,
		REQ_INIT    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		WK_GREY  = 2'd0,
		WK_DOT   = 2'd1,
		WK_LATCH = 2'd2
	} word_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_GREY,
		BK_DOT,
		BK_LATCH
	} back_state_t;

	typedef enum logic [1:0] {
		CLR_BLUE  = 2'd0,
		CLR_GREEN = 2'd1,
		CLR_RED   = 2'd2
	} colour_t;

	typedef struct packed {
		req_t       kind;
		logic [2:0] column;
		logic [2:0] row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [ADDR_W-1:0] pixel_addr(input logic [2:0] col,
			input logic [ROW_W-1:0] row);
		int a;
		a = int'(col) * MATRIX_ROWS + int'(row);
		return ADDR_W'(a);
	endfunction

endpackage

`default_nettype wire

FILE: src/led_matrix_column_refresh.sv
// led_matrix_column_refresh: a set pixel is taken at the port, held in the front register
// and the queue, and written to the store when the back end pops it. a refresh gives
// 24 grey words (one row read plus three words per row) and a latch word. an init gives
// 24 dot words, one per cycle.
// arst_n clears all control state and the per-pixel valid bits, so the store reads zero
// at once; there is no clearing pass. results cannot be stalled.
`default_nettype none

module led_matrix_column_refresh (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] req_type,
	input  wire logic [2:0] column,
	input  wire logic [2:0] row,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic            strobe,
	output logic [1:0]      word_kind,
	output logic [7:0]      shift_word,
	output logic [7:0]      line_enable,
	output logic            last
);
	import lmcr_pkg::*;

	q_status_t q_status;
	logic      push;
	logic      pop;
	cmd_t      push_cmd;
	cmd_t      head;

	lmcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.column   (column),
		.row      (row),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lmcr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	lmcr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.strobe      (strobe),
		.word_kind   (word_kind),
		.shift_word  (shift_word),
		.line_enable (line_enable),
		.last        (last)
	);

endmodule

`default_nettype wire

FILE: src/lmcr_front.sv
// lmcr_front: takes requests, drops the ones that do nothing, holds one decoded command
// depends on lmcr_pkg; feeds lmcr_queue
`default_nettype none

module lmcr_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          req_type,
	input  wire logic [2:0]          column,
	input  wire logic [2:0]          row,
	input  wire logic [7:0]          red,
	input  wire logic [7:0]          green,
	input  wire logic [7:0]          blue,
	input  wire lmcr_pkg::q_status_t q_status,
	output logic                     push,
	output lmcr_pkg::cmd_t           push_cmd
);
	import lmcr_pkg::*;

	logic accept;
	logic keep;
	logic vld_s1;
	cmd_t cmd_s1;

	assign busy   = vld_s1 && q_status.full;
	assign accept = start && !busy;
	assign push   = vld_s1 && !q_status.full;
	assign push_cmd = cmd_s1;

	// unknown requests and set pixel outside the matrix are dropped here
	always_comb begin
		case (req_t'(req_type))
			REQ_SET:     keep = (int'(column) < MATRIX_COLUMNS) && (int'(row) < MATRIX_ROWS);
			REQ_REFRESH: keep = 1'b1;
			REQ_INIT:    keep = 1'b1;
			default:     keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= keep;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= '{kind: req_t'(req_type), column: column, row: row,
				red: red, green: green, blue: blue};
		end
	end

endmodule

`default_nettype wire

FILE: src/lmcr_queue.sv
// lmcr_queue: two-entry command queue between front and back end
// depends on lmcr_pkg
`default_nettype none

module lmcr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lmcr_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output lmcr_pkg::cmd_t      head,
	output lmcr_pkg::q_status_t status
);
	import lmcr_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

FILE: src/lmcr_back.sv
// lmcr_back: pixel store and word sequencer, runs one queued command at a time
// depends on lmcr_pkg; drives the result ports
`default_nettype none

module lmcr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lmcr_pkg::cmd_t      head,
	input  wire lmcr_pkg::q_status_t q_status,
	output logic                     pop,
	output logic                     strobe,
	output logic [1:0]               word_kind,
	output logic [7:0]               shift_word,
	output logic [7:0]               line_enable,
	output logic                     last
);
	import lmcr_pkg::*;

	back_state_t state_q, state_d;
	logic [2:0]       col_q, col_d;
	logic             in_matrix_q, in_matrix_d;
	logic [ROW_W-1:0] row_q, row_d;
	colour_t          colour_q, colour_d;
	logic [4:0]       word_cnt_q, word_cnt_d;

	// pixel store: one 24-bit entry per pixel, blue in the low byte
	logic [23:0]             mem [STORE_PIXELS];
	logic [STORE_PIXELS-1:0] valid_q;
	logic [23:0]             rd_data_s1;
	logic                    rd_valid_s1;
	logic                    mem_we;
	logic [ADDR_W-1:0]       wr_addr;
	logic [ADDR_W-1:0]       rd_addr;
	logic [7:0]              grey_byte;

	logic             emit;
	word_kind_t       kind_d;
	logic [7:0]       word_d;
	logic [7:0]       enable_d;
	logic             last_d;
	logic             strobe_q;
	word_kind_t       kind_q;
	logic [7:0]       word_q;
	logic [7:0]       enable_q;
	logic             last_q;

	assign wr_addr = pixel_addr(head.column, ROW_W'(head.row));
	assign rd_addr = pixel_addr(col_q, row_q);

	always_comb begin
		case (colour_q)
			CLR_BLUE:  grey_byte = rd_data_s1[7:0];
			CLR_GREEN: grey_byte = rd_data_s1[15:8];
			default:   grey_byte = rd_data_s1[23:16];
		endcase
		if (!(in_matrix_q && rd_valid_s1)) begin
			grey_byte = 8'h00;
		end
	end

	always_comb begin
		state_d     = state_q;
		col_d       = col_q;
		in_matrix_d = in_matrix_q;
		row_d       = row_q;
		colour_d    = colour_q;
		word_cnt_d  = word_cnt_q;
		pop         = 1'b0;
		mem_we      = 1'b0;
		emit        = 1'b0;
		kind_d      = WK_GREY;
		word_d      = 8'h00;
		enable_d    = 8'h00;
		last_d      = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					pop = 1'b1;
					case (head.kind)
						REQ_SET: begin
							mem_we = 1'b1;
						end
						REQ_REFRESH: begin
							col_d       = head.column;
							in_matrix_d = int'(head.column) < MATRIX_COLUMNS;
							row_d       = '0;
							state_d     = BK_READ;
						end
						REQ_INIT: begin
							word_cnt_d = 5'd0;
							state_d    = BK_DOT;
						end
						default: ;
					endcase
				end
			end
			BK_READ: begin
				colour_d = CLR_BLUE;
				state_d  = BK_GREY;
			end
			BK_GREY: begin
				emit   = 1'b1;
				word_d = grey_byte;
				case (colour_q)
					CLR_BLUE:  colour_d = CLR_GREEN;
					CLR_GREEN: colour_d = CLR_RED;
					default: begin
						if (row_q == ROW_W'(MATRIX_ROWS - 1)) begin
							state_d = BK_LATCH;
						end else begin
							row_d   = row_q + ROW_W'(1);
							state_d = BK_READ;
						end
					end
				endcase
			end
			BK_LATCH: begin
				emit     = 1'b1;
				kind_d   = WK_LATCH;
				enable_d = ENABLE_COL0 >> col_q;
				last_d   = 1'b1;
				state_d  = BK_IDLE;
			end
			BK_DOT: begin
				emit       = 1'b1;
				kind_d     = WK_DOT;
				word_d     = DOT_ALL_ONES;
				word_cnt_d = word_cnt_q + 5'd1;
				if (word_cnt_q == 5'(DOT_WORDS - 1)) begin
					last_d     = 1'b1;
					word_cnt_d = 5'd0;
					state_d    = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			word_cnt_q <= 5'd0;
			valid_q    <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			word_cnt_q <= word_cnt_d;
			strobe_q   <= emit;
			if (mem_we) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		col_q       <= col_d;
		in_matrix_q <= in_matrix_d;
		row_q       <= row_d;
		colour_q    <= colour_d;
		kind_q      <= kind_d;
		word_q      <= word_d;
		enable_q    <= enable_d;
		last_q      <= last_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= {head.red, head.green, head.blue};
		end
		rd_data_s1  <= mem[rd_addr];
		rd_valid_s1 <= valid_q[rd_addr];
	end

	assign strobe      = strobe_q;
	assign word_kind   = kind_q;
	assign shift_word  = word_q;
	assign line_enable = enable_q;
	assign last        = last_q;

	// the line stays dark while words are shifted
	a_dark_while_shift: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && kind_q != WK_LATCH |-> enable_q == 8'h00)
		else $error("line enabled during shift");

	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $onehot0(enable_q))
		else $error("line enable not one-hot");

	a_grey_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |-> kind_q != WK_GREY)
		else $error("grey word marked last");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == BK_IDLE && !q_status.empty)
		else $error("command taken while back end busy");

	a_dot_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DOT |=> strobe_q && kind_q == WK_DOT)
		else $error("dot word missing");

endmodule

`default_nettype wire
